// ===== rtl/cbc_pkg.sv =====
package cbc_pkg;

  // Configuration register indexes.
  localparam logic [7:0] CfgCartType = 8'd0;
  localparam logic [7:0] CfgRamSize  = 8'd1;

  // Reset value of the usable RAM window.
  localparam logic [13:0] RamSizeReset = 14'd8192;

  // Magic low nibble that enables external RAM.
  localparam logic [3:0] RamEnableKey = 4'hA;

  // Control region selected by address bits 14:13 below 0x8000.
  localparam logic [1:0] RegionEnable = 2'd0;
  localparam logic [1:0] RegionRomBank = 2'd1;
  localparam logic [1:0] RegionUpper = 2'd2;
  localparam logic [1:0] RegionMode = 2'd3;

  // Address bits 15:13 of the external RAM window at 0xA000-0xBFFF.
  localparam logic [2:0] RamWindow = 3'b101;

  // MBC3 RTC register range and latch bytes.
  localparam logic [3:0] RtcFirst = 4'h8;
  localparam logic [3:0] RtcLast = 4'hC;
  localparam logic [3:0] RamSelLimit = 4'h4;
  localparam logic [7:0] LatchLow = 8'h00;
  localparam logic [7:0] LatchHigh = 8'h01;

  typedef enum logic [2:0] {
    KIND_PLAIN,
    KIND_MBC1,
    KIND_MBC2,
    KIND_MBC3,
    KIND_MBC5
  } kind_t;

  // Bank controller state.
  typedef struct packed {
    logic       ram_en;
    logic [8:0] rom_sel;
    logic [3:0] upper;
    logic [3:0] ram_bank;
    logic       mode;
    logic       rtc_sel;
    logic [1:0] latch;
  } cbc_state_t;

  // One result transaction.
  typedef struct packed {
    logic [8:0]  rom_bank_out;
    logic [3:0]  ram_bank_out;
    logic        ram_enabled;
    logic        ram_write;
    logic [12:0] ram_offset;
    logic [7:0]  ram_data;
    logic        rtc_selected;
    logic        rtc_latched;
  } cbc_result_t;

  // Header type byte to controller kind; unknown types act as plain banking.
  function automatic kind_t kind_of(input logic [7:0] t);
    kind_t k;
    case (t)
      8'h01, 8'h02, 8'h03: k = KIND_MBC1;
      8'h05, 8'h06: k = KIND_MBC2;
      8'h10, 8'h11, 8'h12, 8'h13: k = KIND_MBC3;
      8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E: k = KIND_MBC5;
      default: k = KIND_PLAIN;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/cartridge_bank_controller.sv =====
// Bank controller for a handheld console cartridge. Each input transaction
// is one CPU write (address, byte); the controller kind (plain, MBC1, MBC2,
// MBC3, MBC5) follows the cart_type register, and every write returns one
// result transaction with the banks and flags after the write plus any gated
// external-RAM write. A transaction is accepted every cycle while the skid
// entry is empty; results go into the output register, and while the output
// stalls, the two-entry buffer's skid entry takes one more write. State
// is updated in one pass of decode logic per write. Configuration writes
// (index 0 cart_type, index 1 ram_usable_size) are always ready outside reset.
module cartridge_bank_controller import cbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] address,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [8:0]  rom_bank_out,
  output logic [3:0]  ram_bank_out,
  output logic        ram_enabled,
  output logic        ram_write,
  output logic [12:0] ram_offset,
  output logic [7:0]  ram_data,
  output logic        rtc_selected,
  output logic        rtc_latched,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  logic [7:0]  cart_type;
  logic [13:0] ram_usable_size;
  cbc_state_t  state;
  cbc_state_t  state_next;
  cbc_result_t result;
  cbc_result_t out_data;
  logic        accept;

  assign cfg_ready = !rst;
  assign accept = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cart_type <= 8'd0;
      ram_usable_size <= RamSizeReset;
    end else if (cfg_valid) begin
      if (cfg_index == CfgCartType) cart_type <= cfg_data[7:0];
      else if (cfg_index == CfgRamSize) ram_usable_size <= cfg_data;
    end
  end

  // Controller state, updated on each accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{ram_en: 1'b0, rom_sel: 9'd1, upper: 4'd0, ram_bank: 4'd0,
                 mode: 1'b0, rtc_sel: 1'b0, latch: 2'd0};
    end else if (accept) begin
      state <= state_next;
    end
  end

  cbc_update u_update (
    .state           (state),
    .cart_type       (cart_type),
    .ram_usable_size (ram_usable_size),
    .address         (address),
    .data_byte       (data_byte),
    .state_next      (state_next),
    .result          (result)
  );

  cbc_out_buffer u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign rom_bank_out = out_data.rom_bank_out;
  assign ram_bank_out = out_data.ram_bank_out;
  assign ram_enabled = out_data.ram_enabled;
  assign ram_write = out_data.ram_write;
  assign ram_offset = out_data.ram_offset;
  assign ram_data = out_data.ram_data;
  assign rtc_selected = out_data.rtc_selected;
  assign rtc_latched = out_data.rtc_latched;

endmodule

// ===== rtl/cbc_update.sv =====
module cbc_update import cbc_pkg::*; (
  input  cbc_state_t  state,
  input  logic [7:0]  cart_type,
  input  logic [13:0] ram_usable_size,
  input  logic [15:0] address,
  input  logic [7:0]  data_byte,
  output cbc_state_t  state_next,
  output cbc_result_t result
);

  kind_t       kind;
  logic [1:0]  region;
  logic        ctl_area;
  logic        ram_area;
  logic        ram_ok;
  logic        en_value;
  logic [3:0]  nib;

  assign kind = kind_of(cart_type);
  assign region = address[14:13];
  assign ctl_area = !address[15];
  assign ram_area = (address[15:13] == RamWindow);
  assign en_value = (data_byte[3:0] == RamEnableKey);
  assign nib = data_byte[3:0];

  // Control register writes per controller kind.
  always_comb begin
    state_next = state;
    if (ctl_area) begin
      case (kind)
        KIND_MBC1: begin
          case (region)
            RegionEnable: state_next.ram_en = en_value;
            RegionRomBank: begin
              state_next.rom_sel = {4'd0, data_byte[4:0]};
              if (data_byte[4:0] == 5'd0) state_next.rom_sel = 9'd1;
              if (!state.mode) state_next.rom_sel[6:5] = state.upper[1:0];
            end
            RegionUpper: begin
              state_next.upper = {2'd0, data_byte[1:0]};
              if (state.mode) begin
                state_next.ram_bank = {2'd0, data_byte[1:0]};
              end else begin
                state_next.rom_sel = {2'd0, data_byte[1:0], state.rom_sel[4:0]};
              end
            end
            default: begin
              state_next.mode = data_byte[0];
              if (data_byte[0]) begin
                state_next.ram_bank = {2'd0, state.upper[1:0]};
                state_next.rom_sel = {4'd0, state.rom_sel[4:0]};
              end else begin
                state_next.ram_bank = 4'd0;
                state_next.rom_sel = {2'd0, state.upper[1:0], state.rom_sel[4:0]};
              end
            end
          endcase
        end
        KIND_MBC2: begin
          if (region == RegionEnable && !address[8]) begin
            state_next.ram_en = en_value;
          end else if (region == RegionRomBank && address[8]) begin
            state_next.rom_sel = (nib == 4'd0) ? 9'd1 : {5'd0, nib};
          end
        end
        KIND_MBC3: begin
          case (region)
            RegionEnable: state_next.ram_en = en_value;
            RegionRomBank: begin
              state_next.rom_sel = (data_byte[6:0] == 7'd0) ? 9'd1 : {2'd0, data_byte[6:0]};
            end
            RegionUpper: begin
              state_next.upper = nib;
              if (nib < RamSelLimit) begin
                state_next.ram_bank = nib;
                state_next.rtc_sel = 1'b0;
              end else if (nib >= RtcFirst && nib <= RtcLast) begin
                state_next.rtc_sel = 1'b1;
              end
            end
            default: begin
              // Latch sequence: 0 then 1 enters latched phases, again leaves.
              if (state.latch == 2'd0 && data_byte == LatchLow) state_next.latch = 2'd1;
              else if (state.latch == 2'd1 && data_byte == LatchHigh) state_next.latch = 2'd2;
              else if (state.latch == 2'd2 && data_byte == LatchLow) state_next.latch = 2'd3;
              else if (state.latch == 2'd3 && data_byte == LatchHigh) state_next.latch = 2'd0;
              else state_next.latch = {state.latch[1], 1'b0};
            end
          endcase
        end
        KIND_MBC5: begin
          case (region)
            RegionEnable: state_next.ram_en = en_value;
            RegionRomBank: begin
              if (!address[12]) state_next.rom_sel = {state.rom_sel[8], data_byte};
              else state_next.rom_sel = {data_byte[0], state.rom_sel[7:0]};
            end
            RegionUpper: begin
              state_next.upper = nib;
              state_next.ram_bank = nib;
            end
            default: ;
          endcase
        end
        default: begin
          if (region == RegionEnable) begin
            state_next.ram_en = en_value;
          end else if (region == RegionRomBank) begin
            state_next.rom_sel = (nib == 4'd0) ? 9'd1 : {5'd0, nib};
          end
        end
      endcase
    end
  end

  // External RAM write gating.
  assign ram_ok = ram_area && state.ram_en && ({1'b0, address[12:0]} < ram_usable_size)
                  && !(kind == KIND_MBC3 && state.upper[3]);

  always_comb begin
    result.rom_bank_out = state_next.rom_sel;
    result.ram_bank_out = state_next.ram_bank;
    result.ram_enabled = state_next.ram_en;
    result.ram_write = ram_ok;
    result.ram_offset = ram_ok ? address[12:0] : 13'd0;
    result.ram_data = 8'd0;
    if (ram_ok) result.ram_data = (kind == KIND_MBC2) ? {4'd0, nib} : data_byte;
    result.rtc_selected = state_next.rtc_sel;
    result.rtc_latched = state_next.latch[1];
  end

endmodule

// ===== rtl/cbc_out_buffer.sv =====
module cbc_out_buffer import cbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  cbc_result_t push_data,
  output logic        can_push,
  output logic        out_valid,
  input  logic        out_ready,
  output cbc_result_t out_data
);

  logic        skid_valid;
  cbc_result_t skid_data;
  logic        pop;

  assign pop = out_valid && out_ready;
  // Nothing is taken while reset holds the buffer empty.
  assign can_push = !skid_valid && !rst;

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
        skid_valid <= 1'b0;
        out_valid <= 1'b1;
      end else if (push) begin
        out_data <= push_data;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      skid_data <= push_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

// ===== bench/cartridge_bank_controller_tb.sv =====
module cartridge_bank_controller_tb;
  import cbc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // CPU address map boundaries used by the bank logic.
  localparam logic [15:0] AddrRomBank   = 16'h2000;
  localparam logic [15:0] AddrMbc5High  = 16'h3000;
  localparam logic [15:0] AddrUpper     = 16'h4000;
  localparam logic [15:0] AddrMode      = 16'h6000;
  localparam logic [15:0] AddrVram      = 16'h8000;
  localparam logic [15:0] AddrRam       = 16'hA000;
  localparam logic [15:0] AddrWram      = 16'hC000;

  // Register index that no register answers to.
  localparam logic [7:0] CfgUnused = 8'hFF;

  localparam int CycleLimit    = 400000;
  localparam int NumPhases     = 13;
  localparam int ItemsPerPhase = 80;
  localparam int LongHold      = 150;

  // One row of the directed table: a register write or a CPU write.
  typedef struct packed {
    logic        is_cfg;
    logic [7:0]  idx;
    logic [15:0] addr;
    logic [13:0] val;
    logic        has_lit;
    cbc_result_t lit;
  } stim_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] address = '0;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [8:0]  rom_bank_out;
  logic [3:0]  ram_bank_out;
  logic        ram_enabled;
  logic        ram_write;
  logic [12:0] ram_offset;
  logic [7:0]  ram_data;
  logic        rtc_selected;
  logic        rtc_latched;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [13:0] cfg_data = '0;

  // Shadow copy of the controller state and its configuration.
  cbc_state_t  bank_state = '{rom_sel: 9'd1, default: '0};
  logic [7:0]  cur_cart_type = '0;
  logic [13:0] cur_ram_size = RamSizeReset;

  cbc_result_t pending_bank_reports[$];
  stim_row_t   directed_rows[$];

  int mismatches = 0;
  int items_sent = 0;
  int ram_writes_seen = 0;
  int input_stalls = 0;
  int cycle_count = 0;
  int settings_used = 0;
  int hold_cycles_req = 0;
  bit tx_gaps_on = 1'b1;
  bit rx_stalls_on = 1'b1;

  cartridge_bank_controller DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .address      (address),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rom_bank_out (rom_bank_out),
    .ram_bank_out (ram_bank_out),
    .ram_enabled  (ram_enabled),
    .ram_write    (ram_write),
    .ram_offset   (ram_offset),
    .ram_data     (ram_data),
    .rtc_selected (rtc_selected),
    .rtc_latched  (rtc_latched),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Header type byte to controller kind; anything unlisted banks like a plain cart.
  function automatic kind_t controller_kind(input logic [7:0] t);
    if (t >= 8'h01 && t <= 8'h03) return KIND_MBC1;
    if (t == 8'h05 || t == 8'h06) return KIND_MBC2;
    if (t >= 8'h10 && t <= 8'h13) return KIND_MBC3;
    if (t >= 8'h19 && t <= 8'h1E) return KIND_MBC5;
    return KIND_PLAIN;
  endfunction

  // Applies one CPU write to the shadow state and returns the report it produces.
  function automatic cbc_result_t apply_cpu_write(input logic [15:0] a, input logic [7:0] v);
    cbc_result_t r;
    kind_t       k;
    logic [8:0]  b;
    logic [3:0]  m;
    logic        wr_ok;
    r = '0;
    k = controller_kind(cur_cart_type);
    if (a < AddrVram) begin
      case (k)
        KIND_MBC1: begin
          if (a < AddrRomBank) begin
            bank_state.ram_en = (v[3:0] == RamEnableKey);
          end else if (a < AddrUpper) begin
            b = {4'h0, v[4:0]};
            if (b == '0) b = 9'd1;
            if (!bank_state.mode) b[6:5] = bank_state.upper[1:0];
            bank_state.rom_sel = b;
          end else if (a < AddrMode) begin
            bank_state.upper = {2'b00, v[1:0]};
            if (bank_state.mode) bank_state.ram_bank = {2'b00, v[1:0]};
            else bank_state.rom_sel = {2'b00, v[1:0], bank_state.rom_sel[4:0]};
          end else begin
            bank_state.mode = v[0];
            if (v[0]) begin
              bank_state.ram_bank = {2'b00, bank_state.upper[1:0]};
              bank_state.rom_sel = {4'h0, bank_state.rom_sel[4:0]};
            end else begin
              bank_state.ram_bank = '0;
              bank_state.rom_sel = {2'b00, bank_state.upper[1:0], bank_state.rom_sel[4:0]};
            end
          end
        end
        KIND_MBC2: begin
          // Address bit 8 picks between the enable and the bank register.
          if (a < AddrRomBank && !a[8]) begin
            bank_state.ram_en = (v[3:0] == RamEnableKey);
          end else if (a >= AddrRomBank && a < AddrUpper && a[8]) begin
            bank_state.rom_sel = (v[3:0] == '0) ? 9'd1 : {5'h0, v[3:0]};
          end
        end
        KIND_MBC3: begin
          if (a < AddrRomBank) begin
            bank_state.ram_en = (v[3:0] == RamEnableKey);
          end else if (a < AddrUpper) begin
            bank_state.rom_sel = (v[6:0] == '0) ? 9'd1 : {2'b00, v[6:0]};
          end else if (a < AddrMode) begin
            m = v[3:0];
            bank_state.upper = m;
            if (m < RamSelLimit) begin
              bank_state.ram_bank = m;
              bank_state.rtc_sel = 1'b0;
            end else if (m >= RtcFirst && m <= RtcLast) begin
              bank_state.rtc_sel = 1'b1;
            end
          end else begin
            // Latch sequence: 0 then 1 enters the latched phases, again 0 then 1 leaves.
            case (bank_state.latch)
              2'd0: bank_state.latch = (v == LatchLow) ? 2'd1 : 2'd0;
              2'd1: bank_state.latch = (v == LatchHigh) ? 2'd2 : 2'd0;
              2'd2: bank_state.latch = (v == LatchLow) ? 2'd3 : 2'd2;
              default: bank_state.latch = (v == LatchHigh) ? 2'd0 : 2'd2;
            endcase
          end
        end
        KIND_MBC5: begin
          if (a < AddrRomBank) begin
            bank_state.ram_en = (v[3:0] == RamEnableKey);
          end else if (a < AddrMbc5High) begin
            bank_state.rom_sel = {bank_state.rom_sel[8], v};
          end else if (a < AddrUpper) begin
            bank_state.rom_sel = {v[0], bank_state.rom_sel[7:0]};
          end else if (a < AddrMode) begin
            bank_state.upper = v[3:0];
            bank_state.ram_bank = v[3:0];
          end
        end
        default: begin
          if (a < AddrRomBank) begin
            bank_state.ram_en = (v[3:0] == RamEnableKey);
          end else if (a < AddrUpper) begin
            bank_state.rom_sel = (v[3:0] == '0) ? 9'd1 : {5'h0, v[3:0]};
          end
        end
      endcase
    end else if (a >= AddrRam && a < AddrWram) begin
      // External RAM write, gated by enable, usable size and MBC3 RTC select.
      wr_ok = bank_state.ram_en && ({1'b0, a[12:0]} < cur_ram_size);
      if (k == KIND_MBC3 && bank_state.upper >= RtcFirst) wr_ok = 1'b0;
      if (wr_ok) begin
        r.ram_write = 1'b1;
        r.ram_offset = a[12:0];
        r.ram_data = (k == KIND_MBC2) ? {4'h0, v[3:0]} : v;
      end
    end
    r.rom_bank_out = bank_state.rom_sel;
    r.ram_bank_out = bank_state.ram_bank;
    r.ram_enabled = bank_state.ram_en;
    r.rtc_selected = bank_state.rtc_sel;
    r.rtc_latched = bank_state.latch[1];
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic stim_row_t cpu_row(input logic [15:0] a, input logic [7:0] v);
    return '{is_cfg: 1'b0, addr: a, val: {6'h0, v}, default: '0};
  endfunction

  function automatic stim_row_t cpu_row_lit(input logic [15:0] a, input logic [7:0] v,
                                            input cbc_result_t lit);
    return '{is_cfg: 1'b0, addr: a, val: {6'h0, v}, has_lit: 1'b1, lit: lit, default: '0};
  endfunction

  function automatic stim_row_t cfg_row(input logic [7:0] i, input logic [13:0] v);
    return '{is_cfg: 1'b1, idx: i, val: v, default: '0};
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // Offers one CPU write and holds it until accepted, then idles at random if gaps are on.
  task automatic send_cpu_write(input logic [15:0] a, input logic [7:0] v,
                                input cbc_result_t report);
    int gap;
    address <= a;
    data_byte <= v;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_bank_reports.push_back(report);
    items_sent++;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every report has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bank_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Register write transaction; the block must be idle.
  task automatic write_register(input logic [7:0] i, input logic [13:0] v);
    cfg_index <= i;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (i == CfgCartType) cur_cart_type = v[7:0];
    else if (i == CfgRamSize) cur_ram_size = v;
    @(posedge clk);
  endtask

  // Checks each report against the oldest expectation and drives output backpressure.
  always @(posedge clk) begin
    cbc_result_t got;
    cbc_result_t want;
    int          stall_left;
    if (!rst && out_valid && out_ready) begin
      got = '{rom_bank_out, ram_bank_out, ram_enabled, ram_write, ram_offset, ram_data,
              rtc_selected, rtc_latched};
      if (pending_bank_reports.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected report, expected none, actual 0x%0h", $time, got);
      end else begin
        want = pending_bank_reports.pop_front();
        compare_field("rom_bank_out", want.rom_bank_out, got.rom_bank_out);
        compare_field("ram_bank_out", want.ram_bank_out, got.ram_bank_out);
        compare_field("ram_enabled", want.ram_enabled, got.ram_enabled);
        compare_field("ram_write", want.ram_write, got.ram_write);
        compare_field("ram_offset", want.ram_offset, got.ram_offset);
        compare_field("ram_data", want.ram_data, got.ram_data);
        compare_field("rtc_selected", want.rtc_selected, got.rtc_selected);
        compare_field("rtc_latched", want.rtc_latched, got.rtc_latched);
        if (got.ram_write) ram_writes_seen++;
      end
    end
    if (hold_cycles_req > 0) begin
      stall_left = hold_cycles_req;
      hold_cycles_req = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !rst;
      if (rx_stalls_on) stall_left = pick_gap();
    end
  end

  // Cycle budget and input backpressure count.
  always @(posedge clk) begin
    cycle_count++;
    if (in_valid && !in_ready) input_stalls++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: run exceeded %0d cycles with %0d reports outstanding", $time,
               CycleLimit, pending_bank_reports.size());
      $display("cartridge_bank_controller_tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic [7:0]  phase_types [NumPhases] = '{8'h01, 8'h05, 8'h10, 8'h19, 8'h03, 8'h13,
                                             8'h1E, 8'h06, 8'h09, 8'h11, 8'h1B, 8'hFF,
                                             8'h02};
    logic [13:0] phase_sizes [NumPhases] = '{14'd8192, 14'd512, 14'd8192, 14'h3FFF, 14'd0,
                                             14'd8192, 14'd8192, 14'd8192, 14'd4096,
                                             14'd1, 14'd8191, 14'd8192, 14'd2048};
    stim_row_t   row;
    cbc_result_t report;
    logic [15:0] a;
    logic [7:0]  v;
    logic [13:0] size_sel;
    int          r;
    int          o;

    // Directed table: reset values, field extremes and each controller's special cases.
    directed_rows.push_back(cpu_row_lit(16'h0000, 8'h00, '{rom_bank_out: 9'd1, default: '0}));
    directed_rows.push_back(cpu_row_lit(16'hA000, 8'h55, '{rom_bank_out: 9'd1, default: '0}));
    directed_rows.push_back(cpu_row_lit(16'h1FFF, 8'h3A,
                                        '{rom_bank_out: 9'd1, ram_enabled: 1'b1, default: '0}));
    directed_rows.push_back(cpu_row_lit(16'hBFFF, 8'hFF,
                                        '{rom_bank_out: 9'd1, ram_enabled: 1'b1,
                                          ram_write: 1'b1, ram_offset: 13'h1FFF,
                                          ram_data: 8'hFF, default: '0}));
    directed_rows.push_back(cpu_row_lit(16'h2000, 8'h00,
                                        '{rom_bank_out: 9'd1, ram_enabled: 1'b1, default: '0}));
    directed_rows.push_back(cpu_row(16'h3FFF, 8'hFF));
    directed_rows.push_back(cpu_row(16'h8000, 8'hFF));
    directed_rows.push_back(cpu_row(16'hC000, 8'h0A));
    directed_rows.push_back(cpu_row(16'hFFFF, 8'hAA));
    directed_rows.push_back(cpu_row(16'h7FFF, 8'h01));
    directed_rows.push_back(cfg_row(CfgCartType, 14'h01));
    directed_rows.push_back(cpu_row(16'h4000, 8'h03));
    directed_rows.push_back(cpu_row(16'h2000, 8'h00));
    directed_rows.push_back(cpu_row(16'h6000, 8'h01));
    directed_rows.push_back(cpu_row(16'h5FFF, 8'h02));
    directed_rows.push_back(cfg_row(CfgCartType, 14'h05));
    directed_rows.push_back(cpu_row(16'h0100, 8'h00));
    directed_rows.push_back(cpu_row(16'h2100, 8'h00));
    directed_rows.push_back(cpu_row(16'hA123, 8'hFF));
    directed_rows.push_back(cfg_row(CfgCartType, 14'h10));
    directed_rows.push_back(cpu_row(16'h4000, 8'h08));
    directed_rows.push_back(cpu_row(16'hA000, 8'h11));
    directed_rows.push_back(cpu_row(16'h4000, 8'h0D));
    directed_rows.push_back(cpu_row(16'h6000, 8'h00));
    directed_rows.push_back(cpu_row(16'h6000, 8'h01));
    directed_rows.push_back(cpu_row(16'h6000, 8'h05));
    directed_rows.push_back(cpu_row(16'h4000, 8'h03));
    directed_rows.push_back(cfg_row(CfgCartType, 14'h19));
    directed_rows.push_back(cpu_row(16'h3000, 8'h01));
    directed_rows.push_back(cpu_row(16'h2000, 8'hFF));
    directed_rows.push_back(cpu_row(16'h4000, 8'h0F));
    directed_rows.push_back(cfg_row(CfgRamSize, 14'd0));
    directed_rows.push_back(cpu_row(16'hA000, 8'h12));
    directed_rows.push_back(cfg_row(CfgUnused, 14'h3FFF));
    directed_rows.push_back(cfg_row(CfgCartType, 14'hFF));
    directed_rows.push_back(cpu_row(16'h2000, 8'h10));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        drain();
        write_register(row.idx, row.val);
      end else begin
        report = apply_cpu_write(row.addr, row.val[7:0]);
        if (row.has_lit) report = row.lit;
        send_cpu_write(row.addr, row.val[7:0], report);
      end
    end

    // Random phases, one controller setting each, with varied idling on both sides.
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      size_sel = (p == 5) ? 14'($urandom_range(1, 8191)) : phase_sizes[p];
      write_register(CfgCartType, {6'h0, phase_types[p]});
      write_register(CfgRamSize, size_sel);
      settings_used++;
      tx_gaps_on = (p % 4 == 0) || (p % 4 == 2);
      rx_stalls_on = (p % 4 == 0) || (p % 4 == 3);
      // Long output hold while writes keep coming, so the input side backs up.
      if (p == 2 || p == 9) hold_cycles_req = LongHold;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // Sender pause until every report is back, in the middle of one phase.
        if (p == 6 && n == ItemsPerPhase / 2) drain();
        r = $urandom_range(0, 99);
        if (r < 14) a = 16'($urandom_range(16'h0000, 16'h1FFF));
        else if (r < 32) a = 16'($urandom_range(16'h2000, 16'h3FFF));
        else if (r < 46) a = 16'($urandom_range(16'h4000, 16'h5FFF));
        else if (r < 62) a = 16'($urandom_range(16'h6000, 16'h7FFF));
        else if (r < 90) a = 16'($urandom_range(16'hA000, 16'hBFFF));
        else if (r < 95) a = 16'($urandom_range(16'h8000, 16'h9FFF));
        else a = 16'($urandom_range(16'hC000, 16'hFFFF));
        // Aim some RAM writes at the edge of the usable window.
        if (a >= AddrRam && a < AddrWram && cur_ram_size != 0 && $urandom_range(0, 3) == 0) begin
          o = int'(cur_ram_size) - 1 + $urandom_range(0, 1);
          if (o > 8191) o = 8191;
          a = AddrRam + 16'(o);
        end
        r = $urandom_range(0, 99);
        if (r < 25) v = 8'($urandom_range(0, 255));
        else if (r < 50) v = 8'($urandom_range(0, 3));
        else if (r < 70) v = {4'($urandom_range(0, 15)), RamEnableKey};
        else if (r < 85) v = 8'($urandom_range(8, 15));
        else v = 8'($urandom_range(0, 1));
        send_cpu_write(a, v, apply_cpu_write(a, v));
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Covered %0d CPU write transactions over %0d random controller settings",
             items_sent, settings_used);
    $display("plus directed cases; %0d gated RAM writes, %0d input stall cycles, %0d mismatches",
             ram_writes_seen, input_stalls, mismatches);
    if (mismatches == 0) begin
      $display("cartridge_bank_controller_tb OK");
    end else begin
      $display("cartridge_bank_controller_tb NOT OK");
    end
    $finish;
  end

endmodule
